>>> rtl/tpte_pkg.sv
// Shared types and constants of the timestamp pulse train encoder.
package tpte_pkg;

  localparam int TS_BITS   = 42;
  localparam int ID_BITS   = 5;
  localparam int WORD_BITS = TS_BITS + ID_BITS + 2;
  localparam int BITS_W    = $clog2(WORD_BITS + 1);
  localparam int CNT_W     = 18;
  localparam int UNIT_W    = 16;
  localparam int MASK_W    = 8;

  // Word lengths with and without the site ID appended.
  localparam logic [BITS_W-1:0] NBITS_TS_ONLY = BITS_W'(TS_BITS + 1);
  localparam logic [BITS_W-1:0] NBITS_WITH_ID = BITS_W'(WORD_BITS);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_GAP   = 2'd2,
    PH_PULSE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_OUT_MASK  = 2'd0,
    REG_ID_ENABLE = 2'd1,
    REG_SITE_ID   = 2'd2,
    REG_UNIT      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [BITS_W-1:0]    nbits;
  } word_t;

endpackage

>>> rtl/timestamp_pulse_train_encoder.sv
// Top level of the timestamp pulse train encoder: tick stream in, pin levels out.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------
//   in_      | input     | tdata: time_ms[41:0]; tuser: start_train
//   out_     | output    | tdata: pins[7:0];     tuser: busy_res
//   cfg_     | APB       | out_mask, site_id_enable, site_id, unit_ticks
//
// Each input item is one timebase tick and yields exactly one result item.
// One item is taken per cycle while not stalled; its result appears in the output
// register on the next cycle. The only stored work between items is the
// train state (shift word, bit count, phase, unit counter), updated in one pass.
// The input side is ready whenever the output register is empty or being
// drained, so a stalled consumer holds the producer back without losing items.
// Reset (synchronous, active low) returns the train to idle and loads the
// register defaults: mask 255, ID off, site ID 0, 15 ticks per unit.
module timestamp_pulse_train_encoder
  import tpte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [41:0] time_ms, [47:42] zero
  input  logic [0:0]  in_tuser,    // [0] start_train
  // Output pin levels.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] pins
  output logic [0:0]  out_tuser,   // [0] busy_res
  // Configuration.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [MASK_W-1:0]    out_mask_r;
  logic                 id_enable_r;
  logic [ID_BITS-1:0]   site_id_r;
  logic [UNIT_W-1:0]    unit_ticks_r;

  // Train state.
  phase_t               phase_r, phase_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [BITS_W-1:0]    bits_r, bits_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  // Output register.
  logic                 out_valid_r;
  logic [MASK_W-1:0]    pins_r, pins_nxt;
  logic                 busy_r, busy_nxt;

  logic                 in_accept;
  logic                 cfg_write;
  reg_idx_t             cfg_idx;
  logic                 start_load;
  word_t                new_word;
  logic [CNT_W-1:0]     unit_len;
  logic [CNT_W-1:0]     unit_len3;

  // Phase, word, bit count and counter as seen by this tick, after a start.
  phase_t               ph_eff;
  logic [WORD_BITS-1:0] word_eff;
  logic [BITS_W-1:0]    bits_eff;
  logic [CNT_W-1:0]     count_eff;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_mask_r   <= MASK_W'(255);
      id_enable_r  <= 1'b0;
      site_id_r    <= '0;
      unit_ticks_r <= UNIT_W'(15);
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_OUT_MASK:  out_mask_r   <= cfg_pwdata[MASK_W-1:0];
        REG_ID_ENABLE: id_enable_r  <= cfg_pwdata[0];
        REG_SITE_ID:   site_id_r    <= cfg_pwdata[ID_BITS-1:0];
        REG_UNIT:      unit_ticks_r <= cfg_pwdata[UNIT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OUT_MASK:  cfg_prdata = 32'(out_mask_r);
      REG_ID_ENABLE: cfg_prdata = 32'(id_enable_r);
      REG_SITE_ID:   cfg_prdata = 32'(site_id_r);
      REG_UNIT:      cfg_prdata = 32'(unit_ticks_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // A zero unit length behaves as one tick.
  assign unit_len  = (unit_ticks_r == '0) ? CNT_W'(1) : CNT_W'(unit_ticks_r);
  assign unit_len3 = (unit_len << 1) + unit_len;

  tpte_word u_word (
    .time_ms   (in_tdata[TS_BITS-1:0]),
    .site_id   (site_id_r),
    .id_enable (id_enable_r),
    .word_o    (new_word)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // A start request is honored only while idle; the starting tick is already
  // the first tick of the leading pulse.
  always_comb begin
    start_load = (phase_r == PH_IDLE) && in_tuser[0];
    if (start_load) begin
      ph_eff    = PH_FIRST;
      word_eff  = new_word.word;
      bits_eff  = new_word.nbits;
      count_eff = unit_len;
    end else begin
      ph_eff    = phase_r;
      word_eff  = word_r;
      bits_eff  = bits_r;
      count_eff = count_r;
    end
  end

  // Next-state logic: count down the current phase, then move on.
  always_comb begin
    phase_nxt = ph_eff;
    word_nxt  = word_eff;
    bits_nxt  = bits_eff;
    count_nxt = count_eff;
    if (ph_eff != PH_IDLE) begin
      if (count_eff > CNT_W'(1)) begin
        count_nxt = count_eff - CNT_W'(1);
      end else begin
        unique case (ph_eff) inside
          PH_GAP: begin
            phase_nxt = PH_PULSE;
            count_nxt = unit_len;
          end
          PH_FIRST, PH_PULSE: begin
            if (bits_eff != '0) begin
              // Low gap of one unit for a zero bit, three units for a one bit.
              phase_nxt = PH_GAP;
              word_nxt  = word_eff >> 1;
              bits_nxt  = bits_eff - BITS_W'(1);
              count_nxt = word_eff[0] ? unit_len3 : unit_len;
            end else begin
              phase_nxt = PH_IDLE;
              count_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Output logic: pins follow the live mask while a pulse is high.
  always_comb begin
    unique case (ph_eff) inside
      PH_FIRST, PH_PULSE: pins_nxt = out_mask_r;
      default:            pins_nxt = '0;
    endcase
    busy_nxt = (ph_eff != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      word_r  <= '0;
      bits_r  <= '0;
      count_r <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
      bits_r  <= bits_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pins_r <= pins_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = pins_r;
  assign out_tuser[0] = busy_r;

`ifndef NO_ASSERTIONS
  // An idle train has no count left running.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> count_r == '0)
    else $error("idle phase with a nonzero unit counter");

  // The remaining bit count never exceeds the longest word.
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= NBITS_WITH_ID)
    else $error("bit count beyond word length");

  // Pins are low on every result that is not part of a train.
  a_pins_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !busy_r |-> pins_r == '0)
    else $error("pins driven outside a train");

  // An accepted start while idle always opens a train on that tick.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_IDLE && in_tuser[0] |=> busy_r && pins_r == $past(out_mask_r))
    else $error("start did not open a train");
`endif

endmodule

>>> rtl/tpte_word.sv
// Builds the transmitted word: timestamp, its parity, and the optional site ID with parity.
module tpte_word
  import tpte_pkg::*;
(
  input  logic [TS_BITS-1:0] time_ms,
  input  logic [ID_BITS-1:0] site_id,
  input  logic               id_enable,
  output word_t              word_o
);

  logic ts_par;
  logic id_par;

  // Even parity: the appended bit makes the total count of ones even.
  assign ts_par = ^time_ms;
  assign id_par = ^site_id;

  always_comb begin
    if (id_enable) begin
      word_o.word  = {id_par, site_id, ts_par, time_ms};
      word_o.nbits = NBITS_WITH_ID;
    end else begin
      word_o.word  = {{(ID_BITS + 1){1'b0}}, ts_par, time_ms};
      word_o.nbits = NBITS_TS_ONLY;
    end
  end

endmodule

>>> verif/tb.sv
// Self-checking testbench of the timestamp pulse train encoder: predicted pin levels per tick.
module tb;
  import tpte_pkg::*;

  // One predicted tick of the output stream: pin levels and the busy flag.
  typedef struct packed {
    logic [MASK_W-1:0] pins;
    logic              busy;
  } tick_result_t;

  // Patterns that the result side uses for its own back-pressure.
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // [41:0] time_ms, [47:42] zero
  logic [0:0]  in_tuser;    // [0] start_train
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] pins
  logic [0:0]  out_tuser;   // [0] busy_res
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  timestamp_pulse_train_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Register copies kept by the predictor, updated at the same edge as the block's.
  logic [MASK_W-1:0]    mask_q;
  logic                 id_en_q;
  logic [ID_BITS-1:0]   site_q;
  logic [UNIT_W-1:0]    unit_q;

  // Train state of the predictor: word still to send (next bit in bit 0), word bits
  // not yet started, current phase and ticks left in it.
  logic [WORD_BITS-1:0] word_q;
  logic [BITS_W-1:0]    bits_q;
  phase_t               phase_q;
  logic [CNT_W-1:0]     count_q;

  // Expected pin levels, oldest first; filled when an item is accepted.
  tick_result_t pin_levels_due[$];
  int           fail_count = 0;
  int           burst_left = 0;

  // A zero unit length behaves as one tick per unit.
  function automatic logic [CNT_W-1:0] unit_span();
    return (unit_q == '0) ? CNT_W'(1) : CNT_W'(unit_q);
  endfunction

  // Advances the predicted train by one tick and returns what the pins show on it.
  // A start only counts while idle; the starting tick is already the first tick of
  // the opening high pulse. The word is the timestamp, its even parity bit and,
  // when enabled at start, the site ID followed by the ID's own parity bit.
  function automatic tick_result_t encode_tick(input logic start, input logic [TS_BITS-1:0] tms);
    tick_result_t         r;
    logic [WORD_BITS-1:0] w;
    logic                 b;
    if (phase_q == PH_IDLE && start) begin
      w = '0;
      w[TS_BITS-1:0] = tms;
      w[TS_BITS] = ^tms;
      bits_q = NBITS_TS_ONLY;
      if (id_en_q) begin
        w[TS_BITS+1 +: ID_BITS] = site_q;
        w[TS_BITS+ID_BITS+1] = ^site_q;
        bits_q = NBITS_WITH_ID;
      end
      word_q = w;
      phase_q = PH_FIRST;
      count_q = unit_span();
    end
    r.busy = (phase_q != PH_IDLE);
    r.pins = (phase_q == PH_FIRST || phase_q == PH_PULSE) ? mask_q : '0;
    if (phase_q != PH_IDLE) begin
      if (count_q > CNT_W'(1)) begin
        count_q = count_q - CNT_W'(1);
      end else if (phase_q == PH_GAP) begin
        phase_q = PH_PULSE;
        count_q = unit_span();
      end else if (bits_q != '0) begin
        // A one bit is announced by a low gap three units long, a zero by one unit.
        b = word_q[0];
        word_q = word_q >> 1;
        bits_q = bits_q - BITS_W'(1);
        phase_q = PH_GAP;
        count_q = b ? CNT_W'(3) * unit_span() : unit_span();
      end else begin
        phase_q = PH_IDLE;
        count_q = '0;
      end
    end
    return r;
  endfunction

  function automatic logic [TS_BITS-1:0] rand_ms();
    return TS_BITS'({$urandom(), $urandom()});
  endfunction

  // Sends one tick. The sender works in bursts of random length; before a new
  // burst it usually drops valid first, sometimes not at all.
  task automatic send_tick(input logic start, input logic [TS_BITS-1:0] tms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, tms};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    pin_levels_due.push_back(encode_tick(start, tms));
  endtask

  // Stops the input stream and waits until every predicted tick has come out.
  // Each tick yields exactly one result, so nothing is left inside after that.
  task automatic drain_ticks();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reads a register back and compares it with the predictor's copy.
  task automatic cfg_read(input reg_idx_t idx);
    logic [31:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_OUT_MASK:  want = 32'(mask_q);
      REG_ID_ENABLE: want = 32'(id_en_q);
      REG_SITE_ID:   want = 32'(site_q);
      default:       want = 32'(unit_q);
    endcase
    if (cfg_prdata !== want) begin
      $display("%0t register %s read: expected %h, actual %h", $time, idx.name(), want,
               cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Writes a register (setup then access cycle) and reads it back.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_OUT_MASK:  mask_q  = val[MASK_W-1:0];
      REG_ID_ENABLE: id_en_q = val[0];
      REG_SITE_ID:   site_q  = val[ID_BITS-1:0];
      default:       unit_q  = val[UNIT_W-1:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_read(idx);
  endtask

  task automatic set_config(input logic [7:0] mask, input logic id_en, input logic [4:0] site,
                            input logic [15:0] unit);
    drain_ticks();
    cfg_write(REG_OUT_MASK, 32'(mask));
    cfg_write(REG_ID_ENABLE, 32'(id_en));
    cfg_write(REG_SITE_ID, 32'(site));
    cfg_write(REG_UNIT, 32'(unit));
  endtask

  // Starts one train and keeps ticking without starts until it is over.
  task automatic run_train(input logic [TS_BITS-1:0] tms);
    send_tick(1'b1, tms);
    while (phase_q != PH_IDLE) send_tick(1'b0, rand_ms());
  endtask

  // Reset values of every register, then a train opened at the default unit length;
  // the unit length is shortened partway through so that the train ends soon.
  task automatic test_reset_defaults();
    cfg_read(REG_OUT_MASK);
    cfg_read(REG_ID_ENABLE);
    cfg_read(REG_SITE_ID);
    cfg_read(REG_UNIT);
    repeat (3) send_tick(1'b0, rand_ms());
    send_tick(1'b1, '1);
    repeat (40) send_tick(1'b0, rand_ms());
    set_config(8'hFF, 1'b0, 5'd0, 16'd1);
    while (phase_q != PH_IDLE) send_tick(1'b0, rand_ms());
  endtask

  // Timestamp extremes: all zeros, a single low bit (odd parity) and all ones.
  task automatic test_timestamp_extremes();
    set_config(8'hFF, 1'b0, 5'd0, 16'd1);
    run_train('0);
    run_train(TS_BITS'(1));
    run_train('1);
  endtask

  // Site ID appended: lowest ID with the zero mask, highest ID with a single-pin mask.
  task automatic test_site_id();
    set_config(8'h00, 1'b1, 5'd0, 16'd1);
    run_train(rand_ms());
    set_config(8'h80, 1'b1, 5'd31, 16'd1);
    run_train('1);
  endtask

  // Zero unit length acts as one; the largest unit length is set and read back
  // while no train runs, since a full train at that length would take too long.
  task automatic test_unit_extremes();
    set_config(8'hA5, 1'b0, 5'd10, 16'd0);
    run_train(rand_ms());
    set_config(8'h5A, 1'b1, 5'd21, 16'd65535);
    repeat (5) send_tick(1'b0, rand_ms());
    set_config(8'hFF, 1'b1, 5'd6, 16'd2);
    run_train(rand_ms());
  endtask

  // Start held high for a whole train: ignored while busy, accepted again on the
  // first idle tick right after the last pulse.
  task automatic test_start_while_busy();
    set_config(8'h3C, 1'b0, 5'd19, 16'd1);
    send_tick(1'b1, rand_ms());
    while (phase_q != PH_IDLE) send_tick(1'b1, rand_ms());
    send_tick(1'b1, rand_ms());
    while (phase_q != PH_IDLE) send_tick($urandom_range(0, 1), rand_ms());
    repeat (3) send_tick(1'b0, rand_ms());
  endtask

  // Registers rewritten in the middle of a train: the mask applies at once, the
  // unit length at the next phase, while the word and the ID choice stay as started.
  task automatic test_write_mid_train();
    set_config(8'hF0, 1'b0, 5'd3, 16'd2);
    send_tick(1'b1, rand_ms());
    repeat (30) send_tick(1'b0, rand_ms());
    set_config(8'h0F, 1'b1, 5'd28, 16'd1);
    while (phase_q != PH_IDLE) send_tick(1'b0, rand_ms());
    repeat (2) send_tick(1'b0, rand_ms());
  endtask

  // Random traffic in phases of fresh settings. While idle, starts come often so
  // that most ticks belong to trains; starts while busy are the noise. Every
  // other phase runs its train out; the others may stop mid-train.
  task automatic test_random_traffic();
    logic        start;
    logic [7:0]  mask;
    logic [15:0] unit;
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       mask = 8'h00;
        2:       mask = 8'hFF;
        default: mask = 8'($urandom());
      endcase
      unit = (p == 3) ? 16'($urandom_range(4, 8)) : 16'($urandom_range(0, 3));
      set_config(mask, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), unit);
      for (int n = 0; n < 50; n++) begin
        if (phase_q == PH_IDLE) start = ($urandom_range(0, 2) == 0);
        else start = ($urandom_range(0, 9) == 0);
        send_tick(start, rand_ms());
      end
      if (p % 2 == 0) begin
        while (phase_q != PH_IDLE) send_tick(1'b0, rand_ms());
      end
    end
  endtask

  // The result side keeps switching between stall patterns: free
  // running, random stalls, or a fixed ready/stall rhythm.
  initial begin
    rx_mode_t mode;
    int       span;
    out_tready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 200);
      for (int j = 0; j < span; j++) begin
        @(negedge clk);
        case (mode)
          RX_FREE:   out_tready <= 1'b1;
          RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
          default:   out_tready <= ((j % 7) < 3);
        endcase
      end
    end
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_levels_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual pins %h busy %b", $time,
                 out_tdata, out_tuser[0]);
        fail_count++;
      end else begin
        want = pin_levels_due.pop_front();
        if (out_tdata !== want.pins) begin
          $display("%0t pins: expected %h, actual %h", $time, want.pins, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.busy) begin
          $display("%0t busy: expected %b, actual %b", $time, want.busy, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset once, then each test in turn, then the verdict.
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mask_q      = 8'hFF;
    id_en_q     = 1'b0;
    site_q      = '0;
    unit_q      = 16'd15;
    word_q      = '0;
    bits_q      = '0;
    phase_q     = PH_IDLE;
    count_q     = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_timestamp_extremes();
    test_site_id();
    test_unit_extremes();
    test_start_while_busy();
    test_write_mid_train();
    test_random_traffic();
    drain_ticks();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pin_levels_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
